FILE: hw/rtl/tccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_pkg
// Shared types and constants of the text console cursor controller.
// ----------------------------------------------------------------------------
package tccc_pkg;

  // display command codes
  typedef enum logic [2:0] {
    CMD_ERASE  = 3'd0,
    CMD_DRAW   = 3'd1,
    CMD_GLYPH  = 3'd2,
    CMD_SCROLL = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // control character codes
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_CR  = 8'd13;

  // tab stop spacing
  localparam logic [8:0] TAB_STEP = 9'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_TEXT_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_TEXT_ROWS    = 2'd1;
  localparam logic [1:0] CFG_HOME_ROW     = 2'd2;

  // reset values: 1280 / 8 columns, 720 / 8 rows
  localparam logic [7:0] TEXT_COLUMNS_RST = 8'(1280 / 8);
  localparam logic [7:0] TEXT_ROWS_RST    = 8'(720 / 8);
  localparam logic [7:0] HOME_ROW_RST     = 8'd1;
  localparam logic [7:0] CURSOR_ROW_RST   = 8'd1;
  localparam logic [7:0] CURSOR_COL_RST   = 8'd0;

  // commands per character and job queue depth
  localparam int JOB_SLOTS   = 4;
  localparam int SLOT_W      = $clog2(JOB_SLOTS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one display command
  typedef struct packed {
    cmd_e       command;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] glyph;
  } cmd_t;

  // all commands of one character
  typedef struct packed {
    cmd_t [JOB_SLOTS-1:0] cmds;
    logic [SLOT_W-1:0]    last_idx;
  } job_t;

  // screen geometry
  typedef struct packed {
    logic [7:0] text_columns;
    logic [7:0] text_rows;
    logic [7:0] home_row;
  } cfg_t;

  function automatic cmd_t mk_cmd(cmd_e command, logic [7:0] row, logic [7:0] column,
                                  logic [7:0] glyph);
    cmd_t c;
    c.command = command;
    c.row     = row;
    c.column  = column;
    c.glyph   = glyph;
    return c;
  endfunction

endpackage

FILE: hw/rtl/tccc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_front
// Holds geometry and cursor, classifies each character and builds its job.
// ----------------------------------------------------------------------------
module tccc_front import tccc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  input  logic       queue_full_i,
  input  logic [7:0] char_code_i,
  output logic       job_we_o,
  output job_t       job_o
);

  cfg_t       cfg_q;
  logic [7:0] cur_row_q, cur_row_d;
  logic [7:0] cur_col_q, cur_col_d;
  logic       has_cmd;
  logic       accept;

  assign accept   = push && !queue_full_i;
  assign job_we_o = accept && has_cmd;

  // decode one character into its command run and the next cursor
  always_comb begin
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] lastc;
    logic [7:0] lastr;
    logic [8:0] tab_t;
    logic       wrap_c;
    logic       at_bottom;
    r         = cur_row_q;
    c         = cur_col_q;
    lastc     = (cfg_q.text_columns == 8'd0) ? 8'd0 : cfg_q.text_columns - 8'd1;
    lastr     = (cfg_q.text_rows == 8'd0) ? 8'd0 : cfg_q.text_rows - 8'd1;
    tab_t     = {1'b0, c[7:3], 3'b000} + TAB_STEP;
    wrap_c    = (c >= lastc);
    at_bottom = (r >= lastr);
    job_o     = '0;
    has_cmd   = 1'b1;
    cur_row_d = r;
    cur_col_d = c;
    unique case (char_code_i)
      CH_BS: begin
        if (c != 8'd0) begin
          job_o.cmds[0]  = mk_cmd(CMD_ERASE, r, c, 8'd0);
          job_o.cmds[1]  = mk_cmd(CMD_DRAW, r, c - 8'd1, 8'd0);
          job_o.last_idx = 2'd1;
          cur_col_d      = c - 8'd1;
        end else begin
          has_cmd = 1'b0;
        end
      end
      CH_TAB: begin
        job_o.cmds[0] = mk_cmd(CMD_ERASE, r, c, 8'd0);
        if (tab_t < {1'b0, cfg_q.text_columns}) begin
          job_o.cmds[1]  = mk_cmd(CMD_DRAW, r, tab_t[7:0], 8'd0);
          job_o.last_idx = 2'd1;
          cur_col_d      = tab_t[7:0];
        end else if (at_bottom) begin
          job_o.cmds[1]  = mk_cmd(CMD_SCROLL, 8'd0, 8'd0, 8'd0);
          job_o.cmds[2]  = mk_cmd(CMD_DRAW, lastr, 8'd0, 8'd0);
          job_o.last_idx = 2'd2;
          cur_row_d      = lastr;
          cur_col_d      = 8'd0;
        end else begin
          job_o.cmds[1]  = mk_cmd(CMD_DRAW, r + 8'd1, 8'd0, 8'd0);
          job_o.last_idx = 2'd1;
          cur_row_d      = r + 8'd1;
          cur_col_d      = 8'd0;
        end
      end
      CH_LF: begin
        job_o.cmds[0] = mk_cmd(CMD_ERASE, r, c, 8'd0);
        cur_col_d     = 8'd0;
        if (!at_bottom) begin
          job_o.cmds[1]  = mk_cmd(CMD_DRAW, r + 8'd1, 8'd0, 8'd0);
          job_o.last_idx = 2'd1;
          cur_row_d      = r + 8'd1;
        end else begin
          job_o.cmds[1]  = mk_cmd(CMD_SCROLL, 8'd0, 8'd0, 8'd0);
          job_o.cmds[2]  = mk_cmd(CMD_DRAW, lastr, 8'd0, 8'd0);
          job_o.last_idx = 2'd2;
          cur_row_d      = lastr;
        end
      end
      CH_CR: begin
        job_o.cmds[0]  = mk_cmd(CMD_ERASE, r, c, 8'd0);
        job_o.cmds[1]  = mk_cmd(CMD_DRAW, r, 8'd0, 8'd0);
        job_o.last_idx = 2'd1;
        cur_col_d      = 8'd0;
      end
      CH_FF: begin
        job_o.cmds[0]  = mk_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        job_o.cmds[1]  = mk_cmd(CMD_DRAW, cfg_q.home_row, 8'd0, 8'd0);
        job_o.last_idx = 2'd1;
        cur_row_d      = cfg_q.home_row;
        cur_col_d      = 8'd0;
      end
      default: begin
        job_o.cmds[0] = mk_cmd(CMD_ERASE, r, c, 8'd0);
        if (wrap_c && at_bottom) begin
          job_o.cmds[1]  = mk_cmd(CMD_SCROLL, 8'd0, 8'd0, 8'd0);
          job_o.cmds[2]  = mk_cmd(CMD_GLYPH, lastr, 8'd0, char_code_i);
          job_o.cmds[3]  = mk_cmd(CMD_DRAW, lastr, 8'd1, 8'd0);
          job_o.last_idx = 2'd3;
          cur_row_d      = lastr;
          cur_col_d      = 8'd1;
        end else if (wrap_c) begin
          job_o.cmds[1]  = mk_cmd(CMD_GLYPH, r + 8'd1, 8'd0, char_code_i);
          job_o.cmds[2]  = mk_cmd(CMD_DRAW, r + 8'd1, 8'd1, 8'd0);
          job_o.last_idx = 2'd2;
          cur_row_d      = r + 8'd1;
          cur_col_d      = 8'd1;
        end else begin
          job_o.cmds[1]  = mk_cmd(CMD_GLYPH, r, c, char_code_i);
          job_o.cmds[2]  = mk_cmd(CMD_DRAW, r, c + 8'd1, 8'd0);
          job_o.last_idx = 2'd2;
          cur_col_d      = c + 8'd1;
        end
      end
    endcase
  end

  // geometry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_columns <= TEXT_COLUMNS_RST;
      cfg_q.text_rows    <= TEXT_ROWS_RST;
      cfg_q.home_row     <= HOME_ROW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEXT_COLUMNS: cfg_q.text_columns <= cfg_data_i;
        CFG_TEXT_ROWS:    cfg_q.text_rows    <= cfg_data_i;
        CFG_HOME_ROW:     cfg_q.home_row     <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // cursor update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= CURSOR_ROW_RST;
      cur_col_q <= CURSOR_COL_RST;
    end else if (accept) begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

endmodule

FILE: hw/rtl/tccc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_queue
// Small job queue between the decoding front and the issuing back.
// ----------------------------------------------------------------------------
module tccc_queue import tccc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  job_t wr_job_i,
  input  logic rd_en_i,
  output logic full_o,
  output logic empty_o,
  output job_t rd_job_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_wr, do_rd;

  assign full_o   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tccc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_back
// Steps through the commands of the oldest job into the result register.
// ----------------------------------------------------------------------------
module tccc_back import tccc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] command_o,
  output logic [7:0] row_o,
  output logic [7:0] column_o,
  output logic [7:0] glyph_o,
  output logic       last_o
);

  logic              out_valid_q;
  cmd_t              out_q;
  logic              out_last_q;
  logic [SLOT_W-1:0] idx_q;
  logic              load;
  logic              at_last;

  assign load      = job_valid_i && (!out_valid_q || pop);
  assign at_last   = (idx_q == job_i.last_idx);
  assign job_pop_o = load && at_last;

  assign empty     = !out_valid_q;
  assign command_o = out_q.command;
  assign row_o     = out_q.row;
  assign column_o  = out_q.column;
  assign glyph_o   = out_q.glyph;
  assign last_o    = out_last_q;

  // slot counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= at_last ? '0 : idx_q + 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q      <= job_i.cmds[idx_q];
      out_last_q <= at_last;
    end
  end

endmodule

FILE: hw/rtl/text_console_cursor_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_control
// Text cursor tracking and display command generation for a character console.
// ----------------------------------------------------------------------------
// Each character pushed in is decoded combinationally into its run of display
// commands (zero to four) and the cursor is updated at once; the run waits in a
// two-entry job queue and the issue stage hands out one command per cycle,
// while the receiver pops, through a result register, the last command of a
// character marked by last. The sustained rate is set by that issue stage:
// two to four commands per character, none for a backspace at column zero.
// A character is taken while the queue has room, so two queued characters,
// one of them in issue, and the result register can be in flight.
module text_console_cursor_control import tccc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] command_o,
  output logic [7:0] row_o,
  output logic [7:0] column_o,
  output logic [7:0] glyph_o,
  output logic       last_o
);

  logic job_we;
  job_t job_wr;
  logic q_full, q_empty, q_pop;
  job_t job_rd;

  assign full = q_full;

  // decode front
  tccc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .queue_full_i (q_full),
    .char_code_i  (char_code_i),
    .job_we_o     (job_we),
    .job_o        (job_wr)
  );

  // job queue
  tccc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_we),
    .wr_job_i (job_wr),
    .rd_en_i  (q_pop),
    .full_o   (q_full),
    .empty_o  (q_empty),
    .rd_job_o (job_rd)
  );

  // command issue back
  tccc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_rd),
    .job_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .command_o   (command_o),
    .row_o       (row_o),
    .column_o    (column_o),
    .glyph_o     (glyph_o),
    .last_o      (last_o)
  );

`ifndef SYNTH
  // every character run ends by drawing the cursor
  a_last_is_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (command_o == CMD_DRAW))
    else $error("final command of a character is not draw cursor");

  // only glyph writes carry a character code
  a_glyph_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (command_o != CMD_GLYPH)) |-> (glyph_o == 8'd0))
    else $error("glyph set on a non-glyph command");

  // scroll and clear address no cell
  a_screen_cmd_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ((command_o == CMD_SCROLL) || (command_o == CMD_CLEAR)))
      |-> ((row_o == 8'd0) && (column_o == 8'd0)))
    else $error("scroll or clear with nonzero cell");

  // a pending non-final command is followed by another without a gap
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("command run broken inside a character");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console cursor controller.
// ----------------------------------------------------------------------------
// Characters are pushed in under random sender gaps and the command stream is
// drained under random receiver stalls. A scoreboard tracks the cursor and the
// screen geometry on its own, turns every accepted character into its run of
// display commands and compares each popped command field by field. Geometry
// goes through the reset values, both extremes, a shrink that leaves the
// cursor off screen, degenerate sizes below two and a set of small screens.
// ----------------------------------------------------------------------------
module tb;
  import tccc_pkg::*;

  localparam int unsigned TIMEOUT_NS   = 2_000_000;
  localparam int          DRAIN_CYCLES = 16;

  typedef enum {MIX_TEXT, MIX_TABS} mix_e;

  // one expected display command
  typedef struct packed {
    cmd_t cmd;
    logic last;
  } disp_cmd_t;

  // ---------------------------------------------------------------------------
  // cursor and geometry tracking plus command check
  // ---------------------------------------------------------------------------
  class console_scoreboard;
    logic [7:0] text_columns;
    logic [7:0] text_rows;
    logic [7:0] home_row;
    logic [7:0] cur_row;
    logic [7:0] cur_col;
    disp_cmd_t  expected_cmds[$];
    int         errors;

    function new();
      text_columns = TEXT_COLUMNS_RST;
      text_rows    = TEXT_ROWS_RST;
      home_row     = HOME_ROW_RST;
      cur_row      = CURSOR_ROW_RST;
      cur_col      = CURSOR_COL_RST;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_TEXT_COLUMNS: text_columns = value;
        CFG_TEXT_ROWS:    text_rows    = value;
        CFG_HOME_ROW:     home_row     = value;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction

    function void queue_cmd(cmd_e command, int row, int column, int glyph);
      disp_cmd_t d;
      d.cmd.command = command;
      d.cmd.row     = 8'(row);
      d.cmd.column  = 8'(column);
      d.cmd.glyph   = 8'(glyph);
      d.last        = 1'b0;
      expected_cmds.push_back(d);
    endfunction

    // run of commands caused by one accepted character
    function void predict_commands(logic [7:0] ch);
      int r;
      int c;
      int last_c;
      int last_r;
      int tab_stop;
      int first;
      r      = cur_row;
      c      = cur_col;
      last_c = (text_columns != 0) ? int'(text_columns) - 1 : 0;
      last_r = (text_rows != 0) ? int'(text_rows) - 1 : 0;
      first  = expected_cmds.size();
      case (ch)
        CH_BS: begin
          // nothing at all at column zero
          if (c > 0) begin
            queue_cmd(CMD_ERASE, r, c, 0);
            c--;
            queue_cmd(CMD_DRAW, r, c, 0);
          end
        end
        CH_TAB: begin
          tab_stop = (c / int'(TAB_STEP) + 1) * int'(TAB_STEP);
          queue_cmd(CMD_ERASE, r, c, 0);
          if (tab_stop < int'(text_columns)) begin
            c = tab_stop;
          end else if (r >= last_r) begin
            queue_cmd(CMD_SCROLL, 0, 0, 0);
            r = last_r;
            c = 0;
          end else begin
            r++;
            c = 0;
          end
          queue_cmd(CMD_DRAW, r, c, 0);
        end
        CH_LF: begin
          queue_cmd(CMD_ERASE, r, c, 0);
          if (r < last_r) begin
            r++;
          end else begin
            queue_cmd(CMD_SCROLL, 0, 0, 0);
            r = last_r;
          end
          c = 0;
          queue_cmd(CMD_DRAW, r, c, 0);
        end
        CH_CR: begin
          queue_cmd(CMD_ERASE, r, c, 0);
          c = 0;
          queue_cmd(CMD_DRAW, r, c, 0);
        end
        CH_FF: begin
          queue_cmd(CMD_CLEAR, 0, 0, 0);
          r = home_row;
          c = 0;
          queue_cmd(CMD_DRAW, r, c, 0);
        end
        default: begin
          // glyph, wrapping off the last column and scrolling off the last row
          queue_cmd(CMD_ERASE, r, c, 0);
          if (c >= last_c) begin
            if (r >= last_r) begin
              queue_cmd(CMD_SCROLL, 0, 0, 0);
              r = last_r;
            end else begin
              r++;
            end
            c = 0;
          end
          queue_cmd(CMD_GLYPH, r, c, ch);
          c++;
          queue_cmd(CMD_DRAW, r, c, 0);
        end
      endcase
      cur_row = 8'(r);
      cur_col = 8'(c);
      if (expected_cmds.size() > first)
        expected_cmds[expected_cmds.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    // one popped command against the oldest expectation
    function void check_command(logic [2:0] command, logic [7:0] row, logic [7:0] column,
                                logic [7:0] glyph, logic last);
      disp_cmd_t d;
      if (expected_cmds.size() == 0) begin
        $error("command %0d at row %0d column %0d with none expected", command, row,
               column);
        errors++;
      end else begin
        d = expected_cmds.pop_front();
        compare_field("command", 8'(d.cmd.command), 8'(command));
        compare_field("row", d.cmd.row, row);
        compare_field("column", d.cmd.column, column);
        compare_field("glyph", d.cmd.glyph, glyph);
        compare_field("last", 8'(d.last), 8'(last));
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block
  // ---------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_index_i = CFG_TEXT_COLUMNS;
  logic [7:0] cfg_data_i  = 8'd0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] char_code_i = 8'd0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [2:0] command_o;
  logic [7:0] row_o;
  logic [7:0] column_o;
  logic [7:0] glyph_o;
  logic       last_o;

  console_scoreboard sb = new();
  int send_idle = 27;
  int recv_idle = 57;
  int random_sent = 0;

  text_console_cursor_control u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .char_code_i (char_code_i),
    .empty       (empty),
    .pop         (pop),
    .command_o   (command_o),
    .row_o       (row_o),
    .column_o    (column_o),
    .glyph_o     (glyph_o),
    .last_o      (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver with random stalls
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // result transfer check
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_command(command_o, row_o, column_o, glyph_o, last_o);
  end

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch);
    while ($urandom_range(99) < send_idle) begin
      push        <= 1'b0;
      char_code_i <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    push        <= 1'b1;
    char_code_i <= ch;
    do @(posedge clk_i); while (full);
    sb.predict_commands(ch);
  endtask

  // let every expected command come out, then let the pipe settle
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_geometry(input logic [7:0] cols, input logic [7:0] rows,
                                input logic [7:0] home);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TEXT_COLUMNS;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    sb.set_reg(CFG_TEXT_COLUMNS, cols);
    cfg_index_i <= CFG_TEXT_ROWS;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    sb.set_reg(CFG_TEXT_ROWS, rows);
    cfg_index_i <= CFG_HOME_ROW;
    cfg_data_i  <= home;
    @(posedge clk_i);
    sb.set_reg(CFG_HOME_ROW, home);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char(mix_e mix);
    int roll;
    roll = $urandom_range(99);
    if (mix == MIX_TABS)
      return (roll < 75) ? CH_TAB : 8'($urandom_range(255));
    if (roll < 8)  return CH_BS;
    if (roll < 16) return CH_TAB;
    if (roll < 24) return CH_LF;
    if (roll < 30) return CH_CR;
    if (roll < 34) return CH_FF;
    return 8'($urandom_range(255));
  endfunction

  // random characters; idling pattern moves on as the run goes
  task automatic run_random(input int count, input mix_e mix);
    for (int i = 0; i < count; i++) begin
      send_char(pick_char(mix));
      random_sent++;
      if (random_sent == 55) begin
        send_idle = 57;
        recv_idle = 27;
      end else if (random_sent == 110) begin
        send_idle = 0;
        recv_idle = 0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset geometry, every control code and glyph extremes
    send_char(CH_BS);      // column zero, no commands
    send_char(8'h41);
    send_char(CH_BS);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'd11);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(CH_BS);
    send_char(CH_TAB);
    send_char(CH_TAB);
    send_char(8'h20);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_LF);
    send_char(CH_FF);
    send_char(8'h7E);
    send_char(CH_CR);
    send_char(CH_BS);
    wait_drained();

    // smallest legal screen
    write_geometry(8'd2, 8'd2, 8'd0);
    send_char(CH_FF);
    run_random(20, MIX_TEXT);
    wait_drained();

    // largest screen, home on the last row, tabs to reach the far edge
    write_geometry(8'd255, 8'd255, 8'd254);
    send_char(CH_FF);
    run_random(40, MIX_TABS);
    run_random(8, MIX_TEXT);
    wait_drained();

    // shrink with the cursor left off screen, home past the last row
    write_geometry(8'd5, 8'd3, 8'd7);
    run_random(25, MIX_TEXT);
    wait_drained();

    // degenerate sizes below two
    write_geometry(8'd0, 8'd1, 8'd255);
    send_char(CH_FF);
    run_random(6, MIX_TEXT);
    wait_drained();
    write_geometry(8'd1, 8'd0, 8'd3);
    run_random(6, MIX_TEXT);
    wait_drained();

    // assorted small screens
    for (int p = 0; p < 4; p++) begin
      write_geometry(8'($urandom_range(2, 24)), 8'($urandom_range(2, 8)),
                     8'($urandom_range(0, 9)));
      run_random(6, MIX_TEXT);
      wait_drained();
    end

    // back to the reset geometry
    write_geometry(TEXT_COLUMNS_RST, TEXT_ROWS_RST, HOME_ROW_RST);
    run_random(10, MIX_TEXT);
    wait_drained();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("text_console_cursor_control verification clean");
    end else begin
      $display("text_console_cursor_control verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("text_console_cursor_control verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tccc_pkg.sv
hw/rtl/tccc_front.sv
hw/rtl/tccc_queue.sv
hw/rtl/tccc_back.sv
hw/rtl/text_console_cursor_control.sv
bench/tb.sv
